[design/mbbs_pkg.sv]
// ----------------------------------------------------------------------------
// mbbs_pkg
// Shared types for the mesh bounding box and sphere block: the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package mbbs_pkg;

	typedef struct packed {
		logic vtx_upd;
		logic store_wr;
		logic calc_box;
		logic scan_rd;
		logic sqrt_start;
		logic sqrt_step;
		logic out_load;
		logic mesh_clr;
	} cmd_t;

	typedef struct packed {
		logic busy;
	} status_t;

endpackage

[design/mbbs_ctrl.sv]
// ----------------------------------------------------------------------------
// mbbs_ctrl
// Controller: vertex count, store addressing, scan and square-root sequencing,
// overflow flag and result handshake.
// ----------------------------------------------------------------------------
module mbbs_ctrl #(
	parameter int MAX_VERTICES = 1024,
	parameter int POS_WIDTH    = 16,
	parameter int AW           = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_last,
	output logic                in_ready,
	input  logic                out_ready,
	output logic                out_valid,
	output logic                out_ovf,
	output mbbs_pkg::cmd_t      cmd,
	output logic [AW-1:0]       addr,
	input  mbbs_pkg::status_t   status
);

	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int SW = (POS_WIDTH > 1) ? $clog2(POS_WIDTH) : 1;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_VERTICES);
	localparam logic [SW-1:0] STEP_LAST = SW'(POS_WIDTH - 1);

	localparam logic [2:0] S_LOAD = 3'd0;
	localparam logic [2:0] S_BOX  = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_SQRT = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [SW-1:0] step_q;
	logic          ovf_q;
	logic          ovf_out_q;
	logic          out_valid_q;
	logic          in_acc;

	assign in_ready  = (state_q == S_LOAD);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_ovf   = ovf_out_q;

	always_comb begin
		cmd  = '0;
		addr = '0;
		case (state_q)
			S_LOAD: begin
				if (in_acc) begin
					cmd.vtx_upd = 1'b1;
					if (count_q != CNT_MAX) begin
						cmd.store_wr = 1'b1;
						addr         = count_q[AW-1:0];
					end
				end
			end
			S_BOX: begin
				cmd.calc_box = 1'b1;
			end
			S_SCAN: begin
				if (idx_q < count_q) begin
					cmd.scan_rd = 1'b1;
					addr        = idx_q[AW-1:0];
				end else if (!status.busy) begin
					cmd.sqrt_start = 1'b1;
				end
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					cmd.mesh_clr = 1'b1;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			count_q     <= '0;
			idx_q       <= '0;
			step_q      <= '0;
			ovf_q       <= 1'b0;
			ovf_out_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (count_q != CNT_MAX) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (in_last) begin
							state_q <= S_BOX;
						end
					end
				end
				S_BOX: begin
					idx_q   <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (cmd.scan_rd) begin
						idx_q <= idx_q + CW'(1);
					end else if (cmd.sqrt_start) begin
						step_q  <= STEP_LAST;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (step_q == '0) begin
						state_q <= S_DONE;
					end else begin
						step_q <= step_q - SW'(1);
					end
				end
				S_DONE: begin
					if (cmd.out_load) begin
						ovf_out_q <= ovf_q;
						ovf_q     <= 1'b0;
						count_q   <= '0;
						state_q   <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

[design/mbbs_dp.sv]
// ----------------------------------------------------------------------------
// mbbs_dp
// Datapath: per-axis min and max, vertex store, center and half extents,
// distance pipeline with running maximum, bit-serial square root and the
// result register.
// ----------------------------------------------------------------------------
module mbbs_dp #(
	parameter int MAX_VERTICES = 1024,
	parameter int POS_WIDTH    = 16,
	parameter int AW           = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mbbs_pkg::cmd_t              cmd,
	input  logic [AW-1:0]               addr,
	input  logic signed [POS_WIDTH-1:0] pos_x,
	input  logic signed [POS_WIDTH-1:0] pos_y,
	input  logic signed [POS_WIDTH-1:0] pos_z,
	output mbbs_pkg::status_t           status,
	output logic signed [POS_WIDTH-1:0] center_x,
	output logic signed [POS_WIDTH-1:0] center_y,
	output logic signed [POS_WIDTH-1:0] center_z,
	output logic [POS_WIDTH-2:0]        half_x,
	output logic [POS_WIDTH-2:0]        half_y,
	output logic [POS_WIDTH-2:0]        half_z,
	output logic [POS_WIDTH-1:0]        sphere_radius
);

	localparam int P  = POS_WIDTH;
	localparam int DW = 2 * POS_WIDTH;
	localparam logic signed [P-1:0] POS_MAX = {1'b0, {(P-1){1'b1}}};
	localparam logic signed [P-1:0] POS_MIN = {1'b1, {(P-1){1'b0}}};

	logic [3*P-1:0]        mem_q [MAX_VERTICES];
	logic signed [P-1:0]   pos  [3];
	logic signed [P-1:0]   min_q [3];
	logic signed [P-1:0]   max_q [3];
	logic signed [P-1:0]   center_q [3];
	logic [P-2:0]          half_q [3];
	logic signed [P:0]     box_sum [3];
	logic signed [P:0]     box_dif [3];
	logic [3*P-1:0]        rd_s1;
	logic signed [P:0]     off [3];
	logic [P-1:0]          aoff_s2 [3];
	logic [DW-1:0]         sq_s3 [3];
	logic [DW-1:0]         sum_s4;
	logic                  v_s1, v_s2, v_s3, v_s4;
	logic [DW-1:0]         best_q;
	logic [DW-1:0]         rad_q;
	logic [P:0]            rem_q;
	logic [P-1:0]          root_q;
	logic [P+2:0]          rem_try;
	logic [P+2:0]          trial;
	logic [P+2:0]          rem_dif;
	logic signed [P-1:0]   center_o [3];
	logic [P-2:0]          half_o [3];
	logic [P-1:0]          radius_o;

	assign pos[0] = pos_x;
	assign pos[1] = pos_y;
	assign pos[2] = pos_z;

	assign status.busy = v_s1 || v_s2 || v_s3 || v_s4;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			box_sum[j] = {min_q[j][P-1], min_q[j]} + {max_q[j][P-1], max_q[j]};
			box_dif[j] = {max_q[j][P-1], max_q[j]} - {min_q[j][P-1], min_q[j]};
			off[j]     = {rd_s1[j*P+P-1], rd_s1[j*P +: P]}
				- {center_q[j][P-1], center_q[j]};
		end
	end

	assign rem_try = {rem_q, rad_q[DW-1:DW-2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign rem_dif = rem_try - trial;

	// box tracking and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 3; j++) begin
				min_q[j] <= POS_MAX;
				max_q[j] <= POS_MIN;
			end
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (cmd.mesh_clr) begin
				for (int j = 0; j < 3; j++) begin
					min_q[j] <= POS_MAX;
					max_q[j] <= POS_MIN;
				end
			end else if (cmd.vtx_upd) begin
				for (int j = 0; j < 3; j++) begin
					if (pos[j] < min_q[j]) begin
						min_q[j] <= pos[j];
					end
					if (pos[j] > max_q[j]) begin
						max_q[j] <= pos[j];
					end
				end
			end
			v_s1 <= cmd.scan_rd;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// vertex store
	always_ff @(posedge clk) begin
		if (cmd.store_wr) begin
			mem_q[addr] <= {pos_z, pos_y, pos_x};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_rd) begin
			rd_s1 <= mem_q[addr];
		end
	end

	// distance pipeline, running maximum, square root, result
	always_ff @(posedge clk) begin
		if (cmd.calc_box) begin
			for (int j = 0; j < 3; j++) begin
				center_q[j] <= box_sum[j][P:1];
				half_q[j]   <= box_dif[j][P-1:1];
			end
		end
		for (int j = 0; j < 3; j++) begin
			aoff_s2[j] <= off[j][P] ? P'(-off[j]) : off[j][P-1:0];
			sq_s3[j]   <= aoff_s2[j] * aoff_s2[j];
		end
		sum_s4 <= sq_s3[0] + sq_s3[1] + sq_s3[2];
		if (cmd.calc_box) begin
			best_q <= '0;
		end else if (v_s4 && (sum_s4 > best_q)) begin
			best_q <= sum_s4;
		end
		if (cmd.sqrt_start) begin
			rad_q  <= best_q;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q <= {rad_q[DW-3:0], 2'b00};
			if (!rem_dif[P+2]) begin
				rem_q  <= rem_dif[P:0];
				root_q <= {root_q[P-2:0], 1'b1};
			end else begin
				rem_q  <= rem_try[P:0];
				root_q <= {root_q[P-2:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			for (int j = 0; j < 3; j++) begin
				center_o[j] <= center_q[j];
				half_o[j]   <= half_q[j];
			end
			radius_o <= root_q;
		end
	end

	assign center_x      = center_o[0];
	assign center_y      = center_o[1];
	assign center_z      = center_o[2];
	assign half_x        = half_o[0];
	assign half_y        = half_o[1];
	assign half_z        = half_o[2];
	assign sphere_radius = radius_o;

endmodule

[design/mesh_bounding_box_and_sphere_top.sv]
// ----------------------------------------------------------------------------
// mesh_bounding_box_and_sphere_top
// Axis-aligned bounding box of a vertex stream with center, half extents and
// the radius of the sphere about the center that holds every stored vertex.
//
// channel   direction  carries
// s_axis    in         one vertex per beat, tlast on the final vertex
// m_axis    out        one result beat per mesh, tuser = overflow flag
//
// Vertices load at one per cycle while the controller is in its load state;
// s_axis_tready is low from the last vertex of a mesh until its result loads.
// After the last vertex of a mesh of N stored vertices: a box step, N store
// reads, a drain of the distance stages, a root start, the square-root steps
// (one root bit each), then the result register loads; the length of the run is
// set by the single store read port and the bit-serial root. Reset clears box,
// count and flags; the store is not cleared. A result waiting on m_axis_tready
// does not block loading of the next mesh; only its own result load waits.
// ----------------------------------------------------------------------------
module mesh_bounding_box_and_sphere_top #(
	parameter int MAX_VERTICES = 1024,
	parameter int POS_WIDTH    = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       s_axis_tvalid,
	output logic                                       s_axis_tready,
	// pos_x, pos_y, pos_z, zero fill
	input  logic [((3*POS_WIDTH+7)/8)*8-1:0]           s_axis_tdata,
	input  logic                                       s_axis_tlast,
	output logic                                       m_axis_tvalid,
	input  logic                                       m_axis_tready,
	// center_x, center_y, center_z, half_x, half_y, half_z, sphere_radius, zero fill
	output logic [((7*POS_WIDTH-3+7)/8)*8-1:0]         m_axis_tdata,
	// overflowed
	output logic                                       m_axis_tuser
);

	localparam int P   = POS_WIDTH;
	localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int OW  = ((7*POS_WIDTH-3+7)/8)*8;
	localparam int OPW = 7*POS_WIDTH-3;

	mbbs_pkg::cmd_t    cmd;
	mbbs_pkg::status_t status;
	logic [AW-1:0]     addr;
	logic signed [P-1:0] center_x, center_y, center_z;
	logic [P-2:0]      half_x, half_y, half_z;
	logic [P-1:0]      sphere_radius;

	mbbs_ctrl #(
		.MAX_VERTICES (MAX_VERTICES),
		.POS_WIDTH    (POS_WIDTH),
		.AW           (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_last   (s_axis_tlast),
		.in_ready  (s_axis_tready),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ovf   (m_axis_tuser),
		.cmd       (cmd),
		.addr      (addr),
		.status    (status)
	);

	mbbs_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.POS_WIDTH    (POS_WIDTH),
		.AW           (AW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.addr          (addr),
		.pos_x         (s_axis_tdata[P-1:0]),
		.pos_y         (s_axis_tdata[2*P-1:P]),
		.pos_z         (s_axis_tdata[3*P-1:2*P]),
		.status        (status),
		.center_x      (center_x),
		.center_y      (center_y),
		.center_z      (center_z),
		.half_x        (half_x),
		.half_y        (half_y),
		.half_z        (half_z),
		.sphere_radius (sphere_radius)
	);

	assign m_axis_tdata = OW'({sphere_radius, half_z, half_y, half_x,
		center_z, center_y, center_x}) & {{(OW-OPW){1'b0}}, {OPW{1'b1}}};

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams meshes into mesh_bounding_box_and_sphere_top and checks every result
// beat against a box, center and sphere predictor kept in step with accepted
// vertex beats. Covers single-vertex meshes, full-range boxes, floor rounding
// of negative sums, a mesh that overruns the vertex store, and random meshes,
// with random gaps on the vertex side and random stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;

	localparam int MAX_VERTICES = 1024;
	localparam int POS_WIDTH    = 16;
	localparam int IN_W         = ((3*POS_WIDTH+7)/8)*8;
	localparam int OUT_W        = ((7*POS_WIDTH-3+7)/8)*8;
	localparam int IDLE_LIMIT   = 20000;
	localparam int END_CYCLES   = 100;

	typedef struct {
		logic [15:0] center_x;
		logic [15:0] center_y;
		logic [15:0] center_z;
		logic [14:0] half_x;
		logic [14:0] half_y;
		logic [14:0] half_z;
		logic [15:0] sphere_radius;
		logic        overflowed;
	} mesh_bounds_t;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;
	logic             s_axis_tlast;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic             m_axis_tuser;

	mesh_bounds_t expected_bounds[$];
	int           error_count = 0;
	int           idle_cycles = 0;
	int           ready_hold = 0;
	bit           sender_steady;
	bit           receiver_steady;

	// predictor state for the mesh being loaded
	int  box_lo[3];
	int  box_hi[3];
	int  stored_pos[MAX_VERTICES][3];
	int  stored_count;
	bit  store_overrun;

	mesh_bounding_box_and_sphere_top #(
		.MAX_VERTICES(MAX_VERTICES),
		.POS_WIDTH(POS_WIDTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned root;
		longint unsigned bitpos;
		root = 0;
		bitpos = 64'd1 << 62;
		while (bitpos > n)
			bitpos = bitpos >> 2;
		while (bitpos != 0) begin
			if (n >= root + bitpos) begin
				n = n - (root + bitpos);
				root = (root >> 1) + bitpos;
			end else begin
				root = root >> 1;
			end
			bitpos = bitpos >> 2;
		end
		return root;
	endfunction

	task automatic clear_mesh_model();
		for (int a = 0; a < 3; a++) begin
			box_lo[a] = 32767;
			box_hi[a] = -32768;
		end
		stored_count = 0;
		store_overrun = 0;
	endtask

	task automatic track_vertex(input logic [15:0] px, input logic [15:0] py,
			input logic [15:0] pz, input logic last);
		int p[3];
		int center[3];
		int halfext[3];
		longint off;
		longint unsigned dist2;
		longint unsigned best;
		mesh_bounds_t r;
		p[0] = $signed(px);
		p[1] = $signed(py);
		p[2] = $signed(pz);
		for (int a = 0; a < 3; a++) begin
			if (p[a] < box_lo[a]) box_lo[a] = p[a];
			if (p[a] > box_hi[a]) box_hi[a] = p[a];
		end
		if (stored_count < MAX_VERTICES) begin
			for (int a = 0; a < 3; a++)
				stored_pos[stored_count][a] = p[a];
			stored_count++;
		end else begin
			store_overrun = 1;
		end
		if (!last)
			return;
		for (int a = 0; a < 3; a++) begin
			center[a] = (box_lo[a] + box_hi[a]) >>> 1;
			halfext[a] = (box_hi[a] - box_lo[a]) >>> 1;
		end
		best = 0;
		for (int i = 0; i < stored_count; i++) begin
			dist2 = 0;
			for (int a = 0; a < 3; a++) begin
				off = longint'(stored_pos[i][a]) - longint'(center[a]);
				dist2 += longint'(off * off);
			end
			if (dist2 > best)
				best = dist2;
		end
		r.center_x = center[0][15:0];
		r.center_y = center[1][15:0];
		r.center_z = center[2][15:0];
		r.half_x = halfext[0][14:0];
		r.half_y = halfext[1][14:0];
		r.half_z = halfext[2][14:0];
		r.sphere_radius = 16'(int_sqrt(best));
		r.overflowed = store_overrun;
		expected_bounds.push_back(r);
		clear_mesh_model();
	endtask

	function automatic int pick_idle(input bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(25, 80);
	endfunction

	task automatic report_mismatch(input string field, input longint got,
			input longint want);
		$display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $time, field, got, want);
		error_count++;
	endtask

	task automatic send_vertex(input logic [15:0] px, input logic [15:0] py,
			input logic [15:0] pz, input logic last);
		int gap;
		bit taken;
		gap = pick_idle(sender_steady);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {pz, py, px};
		s_axis_tlast <= last;
		// ready is settled mid-cycle and holds until the next rising edge
		do begin
			@(negedge clk);
			taken = s_axis_tready;
			@(posedge clk);
		end while (!taken);
		track_vertex(px, py, pz, last);
	endtask

	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (expected_bounds.size() != 0);
	endtask

	function automatic logic [15:0] rand_pos(input int style);
		case (style)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 600) - 300);
			2: begin
				case ($urandom_range(0, 6))
					0: return 16'h8000;
					1: return 16'h8001;
					2: return 16'hFFFF;
					3: return 16'h0000;
					4: return 16'h0001;
					5: return 16'h7FFE;
					default: return 16'h7FFF;
				endcase
			end
			default: return 16'($urandom_range(0, 8191) + 12000);
		endcase
	endfunction

	// result side: checking and watchdog, sampled mid-cycle for the next rising edge
	always @(negedge clk) begin
		mesh_bounds_t want;
		bit got_beat;
		got_beat = arst_n && m_axis_tvalid && m_axis_tready;
		if (got_beat) begin
			if (expected_bounds.size() == 0) begin
				$display("[%0t] result beat with no mesh pending", $time);
				error_count++;
			end else begin
				want = expected_bounds.pop_front();
				if (m_axis_tdata[15:0] !== want.center_x)
					report_mismatch("center_x", longint'(m_axis_tdata[15:0]),
						longint'(want.center_x));
				if (m_axis_tdata[31:16] !== want.center_y)
					report_mismatch("center_y", longint'(m_axis_tdata[31:16]),
						longint'(want.center_y));
				if (m_axis_tdata[47:32] !== want.center_z)
					report_mismatch("center_z", longint'(m_axis_tdata[47:32]),
						longint'(want.center_z));
				if (m_axis_tdata[62:48] !== want.half_x)
					report_mismatch("half_x", longint'(m_axis_tdata[62:48]),
						longint'(want.half_x));
				if (m_axis_tdata[77:63] !== want.half_y)
					report_mismatch("half_y", longint'(m_axis_tdata[77:63]),
						longint'(want.half_y));
				if (m_axis_tdata[92:78] !== want.half_z)
					report_mismatch("half_z", longint'(m_axis_tdata[92:78]),
						longint'(want.half_z));
				if (m_axis_tdata[108:93] !== want.sphere_radius)
					report_mismatch("sphere_radius", longint'(m_axis_tdata[108:93]),
						longint'(want.sphere_radius));
				if (m_axis_tuser !== want.overflowed)
					report_mismatch("overflowed", longint'(m_axis_tuser),
						longint'(want.overflowed));
			end
		end
		if (got_beat || (arst_n && s_axis_tvalid && s_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// result side: random stalls
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			ready_hold = pick_idle(receiver_steady);
		end
	end

	task automatic test_single_vertex_meshes();
		send_vertex(16'h0000, 16'h0000, 16'h0000, 1'b1);
		send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
		send_vertex(16'h8000, 16'h8000, 16'h8000, 1'b1);
		send_vertex(16'h5555, 16'hAAAA, 16'h5555, 1'b1);
		send_vertex(16'hAAAA, 16'h5555, 16'hAAAA, 1'b1);
	endtask

	task automatic test_full_range_boxes();
		// opposite corners of the whole range in x and y
		send_vertex(16'h8000, 16'h7FFF, 16'hFFFF, 1'b0);
		send_vertex(16'h7FFF, 16'h8000, 16'h0000, 1'b1);
		// negative odd sums round toward minus infinity
		send_vertex(-16'sd3, -16'sd5, -16'sd7, 1'b0);
		send_vertex(16'h0000, 16'h0000, 16'h0000, 1'b0);
		send_vertex(16'h0001, -16'sd2, 16'h0003, 1'b1);
		// largest radius: both far corners stored
		send_vertex(16'h8000, 16'h8000, 16'h8000, 1'b0);
		send_vertex(16'h0000, 16'h0000, 16'h0000, 1'b0);
		send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
	endtask

	task automatic test_store_overflow();
		for (int i = 0; i < MAX_VERTICES; i++)
			send_vertex(rand_pos(1), rand_pos(1), rand_pos(1), 1'b0);
		// not stored: widen the box only
		send_vertex(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
		send_vertex(16'h8000, 16'h7FFF, 16'h8000, 1'b1);
		wait_for_results();
		// count and flag must be cleared for the next mesh
		send_vertex(16'h0064, 16'hFF9C, 16'h0007, 1'b1);
	endtask

	task automatic test_random_meshes();
		int items;
		int meshes;
		int len;
		int style;
		int r;
		items = 0;
		meshes = 0;
		while (items < 110 || meshes < 21) begin
			r = $urandom_range(0, 99);
			if (r < 70) len = $urandom_range(1, 4);
			else if (r < 95) len = $urandom_range(5, 12);
			else len = $urandom_range(13, 40);
			style = $urandom_range(0, 3);
			sender_steady = ($urandom_range(0, 7) == 0);
			receiver_steady = ($urandom_range(0, 7) == 0);
			for (int v = 0; v < len; v++)
				send_vertex(rand_pos(style), rand_pos(style), rand_pos(style),
					v == len - 1);
			items += len;
			meshes++;
			if (meshes == 20)
				wait_for_results();
		end
		sender_steady = 0;
		receiver_steady = 0;
	endtask

	initial begin
		sender_steady = 0;
		receiver_steady = 0;
		clear_mesh_model();
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tlast <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_vertex_meshes();
		test_full_range_boxes();
		test_store_overflow();
		test_random_meshes();

		wait_for_results();
		repeat (END_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

[mesh_bounding_box_and_sphere_top.f]
design/mbbs_pkg.sv
design/mbbs_ctrl.sv
design/mbbs_dp.sv
design/mesh_bounding_box_and_sphere_top.sv
tb/testbench.sv
